// ===== src/sspf_pkg.sv =====
// Shared constants, types and the divide-by-ten helper of the scan peak finder.
package sspf_pkg;

   // Scan length limit and the widths of the fields.
   localparam int MAX_STEPS    = 1024;
   localparam int SampleWidth  = 8;
   localparam int IndexWidth   = 10;
   localparam int IndexMax     = (1 << IndexWidth) - 1;
   localparam int StepCap      = (MAX_STEPS - 1 > IndexMax) ? IndexMax : MAX_STEPS - 1;

   // Filter sum 9*s + x stays below 2560, so twelve bits hold it.
   localparam int SumWidth     = 12;

   // Reciprocal of ten: floor(v * 6554 / 2^16) equals floor(v / 10) for every v below 2560.
   localparam int Div10Shift   = 16;
   localparam int Div10Mult    = 6554;
   localparam int Div10MulW    = 13;
   localparam int Div10ProdW   = SumWidth + Div10MulW;

   // Byte-padded width of the response data word.
   localparam int RspDataWidth = 24;

   // Scan tracking state carried between the top level and the tracker.
   typedef struct packed {
      logic [SampleWidth-1:0] smoothed;
      logic [SampleWidth-1:0] best_smoothed;
      logic [IndexWidth-1:0]  best_index;
      logic [SampleWidth-1:0] best_raw;
      logic [IndexWidth-1:0]  step_count;
      logic                   scan_start;
   } scan_state_type;

   // Quotient by ten through the reciprocal multiply.
   function automatic logic [SampleWidth-1:0] div10(input logic [SumWidth-1:0] value);
      logic [Div10ProdW-1:0] product;
      product = Div10ProdW'(value) * Div10ProdW'(Div10Mult);
      return product[Div10Shift +: SampleWidth];
   endfunction

endpackage

// ===== src/smoothed_scan_peak_finder.sv =====
// Top level of the smoothed scan peak finder: input register, scan state, result register.
//
//   channel   direction  fields (low bit up)                        accepted when
//   req_*     in         tdata: sample[7:0]; tlast: last of scan    req_tvalid && req_tready
//   rsp_*     out        tdata: peak_index[9:0], peak_sample[17:10]  rsp_tvalid && rsp_tready
//
// One request per cycle is taken unless an end of scan stalls; the filter and peak update
// are combinational, a loop through the divide-by-ten multiply and the best-value compare.
// A result is registered once the request that ends the scan leaves the input register.
// Synchronous reset empties both registers and arms the start of a new scan.
// While a result waits, requests that do not end a scan keep flowing; a second
// end of scan stalls in the input register until the waiting result is taken.
module smoothed_scan_peak_finder
   import sspf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // sample[7:0]
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata    // peak_index[9:0], peak_sample[17:10], zeros
);

   logic                   in_valid_ff, in_valid_in;
   logic [SampleWidth-1:0] in_sample_ff;
   logic                   in_last_ff;
   scan_state_type         state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0]  rsp_index_ff;
   logic [SampleWidth-1:0] rsp_sample_ff;
   logic                   advance;
   logic                   req_accept;

   // The held request moves on unless it ends a scan and the result slot is still full.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   sspf_tracker u_tracker (
      .state_cur  (state_ff),
      .sample     (in_sample_ff),
      .scan_end   (in_last_ff),
      .state_next (state_in)
   );

   // Input register.
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_sample_ff <= req_tdata;
         in_last_ff   <= req_tlast;
      end
   end

   // Scan state; the end of a scan arms the next one.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{scan_start: 1'b1, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_last_ff) begin
         rsp_index_ff  <= state_in.best_index;
         rsp_sample_ff <= state_in.best_raw;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RspDataWidth - IndexWidth - SampleWidth)'(0), rsp_sample_ff,
                        rsp_index_ff};

   // The step index never passes its cap.
   a_step_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff.step_count <= IndexWidth'(StepCap))
      else $error("step index beyond its cap");

   // Within a scan the recorded peak never lies after the latest step.
   a_best_order: assert property (@(posedge clock) disable iff (reset)
      !state_ff.scan_start |-> state_ff.best_index <= state_ff.step_count)
      else $error("peak index after the latest step");

   // Ending a scan loads a result and arms a new scan.
   a_end_of_scan: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_tvalid && state_ff.scan_start)
      else $error("end of scan did not load a result");

   // Requests stall only behind a scan end that waits for the result slot.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready)
      else $error("request stalled without cause");

endmodule

// ===== src/sspf_tracker.sv =====
// Low-pass filter step and peak tracking for one sample of a scan.
module sspf_tracker
   import sspf_pkg::*;
(
   input  scan_state_type         state_cur,
   input  logic [SampleWidth-1:0] sample,
   input  logic                   scan_end,
   output scan_state_type         state_next
);

   logic [SumWidth-1:0]   filter_sum;
   logic [SampleWidth-1:0] filter_out;
   logic [IndexWidth:0]   index_inc;
   logic [IndexWidth-1:0] index_next;

   // Smoothed value: floor((9*previous + sample) / 10).
   assign filter_sum = SumWidth'({state_cur.smoothed, 3'b000}) + SumWidth'(state_cur.smoothed)
                       + SumWidth'(sample);
   assign filter_out = div10(filter_sum);

   // Step index advances and holds at the cap on long scans.
   assign index_inc  = {1'b0, state_cur.step_count} + (IndexWidth + 1)'(1);
   assign index_next = (index_inc > (IndexWidth + 1)'(StepCap)) ?
                       IndexWidth'(StepCap) : index_inc[IndexWidth-1:0];

   // The first sample of a scan seeds everything; later ones replace the best on a strict rise.
   // The end of a scan arms the next one.
   always_comb begin
      state_next            = state_cur;
      state_next.scan_start = scan_end;
      if (state_cur.scan_start) begin
         state_next.smoothed      = sample;
         state_next.step_count    = '0;
         state_next.best_smoothed = sample;
         state_next.best_index    = '0;
         state_next.best_raw      = sample;
      end else begin
         state_next.smoothed   = filter_out;
         state_next.step_count = index_next;
         if (filter_out > state_cur.best_smoothed) begin
            state_next.best_smoothed = filter_out;
            state_next.best_index    = index_next;
            state_next.best_raw      = sample;
         end
      end
   end

endmodule

// ===== sim/tb_smoothed_scan_peak_finder.sv =====
// Self-checking testbench for the smoothed scan peak finder with directed and random scans.
`timescale 1ns / 1ps

module tb_smoothed_scan_peak_finder
   import sspf_pkg::*;
();

   localparam int unsigned RandomItems = 1400;
   localparam int unsigned MaxGap      = 11;
   localparam int unsigned HoldAfter   = 20;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned LongRiseAt  = 1000;

   // One finished scan: where the smoothed peak sat and the raw reading there.
   typedef struct packed {
      logic [IndexWidth-1:0]  index;
      logic [SampleWidth-1:0] raw;
   } peak_result_type;

   // One directed request, with the result typed in where it is plain to see.
   typedef struct packed {
      logic [SampleWidth-1:0] reading;
      logic                   end_of_scan;
      bit                     typed;
      peak_result_type        want;
   } scan_row_type;

   // Shapes of the random scans.
   typedef enum int {
      SCAN_NOISE,
      SCAN_FLAT,
      SCAN_EXTREME,
      SCAN_CLIMB,
      SCAN_LONG
   } scan_kind_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [7:0]              req_tdata;   // sample[7:0]
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;   // peak_index[9:0], peak_sample[17:10], zeros

   // Directed scans: one-sample extremes, a flat tie, a fall, a rise and bit patterns.
   scan_row_type directed_rows [17] = '{
      '{8'd0,   1'b1, 1'b1, '{10'd0, 8'd0}},
      '{8'd255, 1'b1, 1'b1, '{10'd0, 8'd255}},
      '{8'd100, 1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd100, 1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd100, 1'b1, 1'b1, '{10'd0, 8'd100}},
      '{8'd200, 1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd0,   1'b1, 1'b1, '{10'd0, 8'd200}},
      '{8'd0,   1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd255, 1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd255, 1'b1, 1'b0, '{10'd0, 8'd0}},
      '{8'h55,  1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'hAA,  1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'hFF,  1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'h01,  1'b1, 1'b0, '{10'd0, 8'd0}},
      '{8'd255, 1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd0,   1'b0, 1'b0, '{10'd0, 8'd0}},
      '{8'd255, 1'b1, 1'b0, '{10'd0, 8'd0}}
   };

   // Predictor state: filter output, best value so far, its step and raw reading.
   logic [SampleWidth-1:0] filt_level  = '0;
   logic [SampleWidth-1:0] peak_level  = '0;
   logic [SampleWidth-1:0] peak_raw    = '0;
   logic [IndexWidth-1:0]  peak_step   = '0;
   logic [IndexWidth-1:0]  step_index  = '0;
   logic                   scan_fresh  = 1'b1;

   peak_result_type pending_peaks [$];
   int unsigned  mismatches     = 0;
   int unsigned  peaks_taken    = 0;
   int unsigned  cycle_count    = 0;
   bit           sender_burst   = 1'b0;
   bit           receiver_burst = 1'b0;
   bit           held_off       = 1'b0;

   smoothed_scan_peak_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the filter by one reading and report the peak when the scan ends.
   function automatic bit track_step(input logic [SampleWidth-1:0] reading,
                                     input logic end_of_scan, output peak_result_type peak);
      int unsigned blend;
      if (scan_fresh) begin
         filt_level = reading;
         step_index = '0;
         peak_level = reading;
         peak_step  = '0;
         peak_raw   = reading;
      end else begin
         blend      = (9 * filt_level + reading) / 10;
         filt_level = blend[SampleWidth-1:0];
         if (step_index < StepCap) begin
            step_index = step_index + 1'b1;
         end
         if (filt_level > peak_level) begin
            peak_level = filt_level;
            peak_step  = step_index;
            peak_raw   = reading;
         end
      end
      peak.index = peak_step;
      peak.raw   = peak_raw;
      scan_fresh = end_of_scan;
      return end_of_scan;
   endfunction

   // Offer one request after a random gap and, on acceptance, record the expected peak if it ends a scan.
   task automatic send_request(input logic [SampleWidth-1:0] reading, input logic end_of_scan,
                               input bit typed, input peak_result_type typed_peak);
      int unsigned     gap;
      peak_result_type peak;
      if (sender_burst) begin
         gap = 0;
      end else begin
         gap = $urandom_range(0, MaxGap);
      end
      if ($urandom_range(0, 47) == 0) begin
         sender_burst = !sender_burst;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= reading;
      req_tlast  <= end_of_scan;
      do @(posedge clock); while (!req_tready);
      if (track_step(reading, end_of_scan, peak)) begin
         pending_peaks.push_back(typed ? typed_peak : peak);
      end
   endtask

   // Drive one whole scan of the given length and shape, ending it with tlast.
   task automatic drive_scan(input int unsigned length, input scan_kind_type kind);
      logic [SampleWidth-1:0] level;
      logic [SampleWidth-1:0] reading;
      int unsigned            ramp;
      level = 8'($urandom_range(0, 255));
      for (int unsigned n = 0; n < length; n++) begin
         unique case (kind)
            SCAN_FLAT: begin
               reading = level;
            end
            SCAN_EXTREME: begin
               reading = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            SCAN_CLIMB: begin
               ramp    = (n * 255) / length + $urandom_range(0, 20);
               reading = (ramp > 255) ? 8'hFF : ramp[SampleWidth-1:0];
            end
            SCAN_LONG: begin
               // Quiet start, then a late climb that keeps rising past the index limit.
               reading = (n < LongRiseAt) ? 8'($urandom_range(0, 40)) : 8'hFF;
            end
            default: begin
               reading = 8'($urandom_range(0, 255));
            end
         endcase
         send_request(reading, n == length - 1, 1'b0, '0);
      end
   endtask

   // Compare one accepted response with the oldest expected peak.
   task automatic check_peak(input logic [RspDataWidth-1:0] word);
      peak_result_type want;
      if (pending_peaks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected response: peak_index %0d peak_sample %0d",
                     word[9:0], word[17:10]);
         end
      end else begin
         want = pending_peaks.pop_front();
         if (word[9:0] !== want.index || word[17:10] !== want.raw) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: peak_index %0d (expected %0d), peak_sample %0d (expected %0d)",
                        word[9:0], want.index, word[17:10], want.raw);
            end
         end
      end
   endtask

   // Response side: random stalls, calm stretches and one long hold-off.
   initial begin
      int unsigned stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && peaks_taken == HoldAfter) begin
            held_off = 1'b1;
            stall    = HoldCycles;
         end else if (receiver_burst) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MaxGap);
         end
         if ($urandom_range(0, 15) == 0) begin
            receiver_burst = !receiver_burst;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         peaks_taken++;
         check_peak(rsp_tdata);
      end
   end

   // Cycle counter that ends a hung run.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_smoothed_scan_peak_finder failed");
      $finish;
   end

   // Reset, directed table, random scans, then drain and report.
   initial begin
      int unsigned   sent_random;
      int unsigned   length;
      scan_kind_type kind;
      bit            long_done;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].reading, directed_rows[i].end_of_scan,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      // Mostly short scans, with one scan long enough to saturate the step index.
      sent_random = 0;
      long_done   = 1'b0;
      while (sent_random < RandomItems) begin
         if (!long_done && sent_random >= 300) begin
            long_done = 1'b1;
            length    = 1024 + $urandom_range(4, 40);
            kind      = SCAN_LONG;
         end else begin
            length = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
            kind   = scan_kind_type'($urandom_range(SCAN_NOISE, SCAN_CLIMB));
         end
         drive_scan(length, kind);
         sent_random += length;
      end
      req_tvalid <= 1'b0;

      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_smoothed_scan_peak_finder passed");
      end else begin
         $display("tb_smoothed_scan_peak_finder failed");
      end
      $finish;
   end

endmodule
